// File: rtl/core/vsas_pkg.sv
// Package for the vital sign alarm supervisor: types, codes and a saturating increment function.
`default_nettype none
package vsas_pkg;
	localparam int CALIB_SAMPLES_DEF = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		ST_INIT = 3'd0,
		ST_CALIB = 3'd1,
		ST_MON = 3'd2,
		ST_ALARM = 3'd3,
		ST_HALT = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		WHY_NONE = 2'd0,
		WHY_OVERDOSE = 2'd1,
		WHY_TACHY = 2'd2,
		WHY_UNACKED = 2'd3
	} why_t;

	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_ACK = 2'd1,
		REQ_RESET = 2'd2
	} req_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FLOW_HIGH_LIMIT = 3'd0,
		CFG_FLOW_LOW_LIMIT = 3'd1,
		CFG_HR_HIGH_LIMIT = 3'd2,
		CFG_HR_LOW_LIMIT = 3'd3,
		CFG_HR_HIGH_RUN = 3'd4,
		CFG_FLOW_LOW_RUN = 3'd5,
		CFG_HR_LOW_RUN = 3'd6,
		CFG_ALARM_ACK_LIMIT = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [15:0] flow_rate;
		logic [11:0] heart_rate;
	} req_t;

	typedef struct packed {
		logic [2:0] fsm_state;
		logic alarm_raised;
		logic [1:0] halt_reason;
	} res_t;

	typedef struct packed {
		logic [15:0] flow_high_limit;
		logic [15:0] flow_low_limit;
		logic [11:0] hr_high_limit;
		logic [11:0] hr_low_limit;
		logic [7:0] hr_high_run;
		logic [7:0] flow_low_run;
		logic [7:0] hr_low_run;
		logic [7:0] alarm_ack_limit;
	} cfg_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v == 8'hFF) ? 8'hFF : v + 8'd1;
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/vital_sign_alarm_supervisor_unit.sv
// Vital sign alarm supervisor, top level.
// Request channel (req_valid, req_stall, req): one beat per event, a sensor
// sample, an acknowledge or a soft reset. Each accepted beat yields exactly
// one result beat on (res_valid, res_stall, res): state after the event,
// alarm flag and latched halt reason.
// The result of an accepted beat is written to the output register, or to
// the skid stage while the receiver stalls. Throughput: one beat per cycle
// while req_stall is low; compare and count logic updates the state registers.
// Config port: cfg_we writes cfg_data into register cfg_index;
// write only while no results are outstanding.
// Reset (arst_n low): state goes to initialising, counters and halt reason
// clear, limits take their defaults, no result is pending.
// Receiver stall: results hold in the output register; one more request is
// taken into the skid stage, then req_stall rises until the output drains.
// req_stall comes from a register and never depends on res_stall directly.
`default_nettype none
module vital_sign_alarm_supervisor_unit
	import vsas_pkg::*;
#(
	parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic res_valid,
	input wire logic res_stall,
	output res_t res,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t cfg;
	res_t step_res;
	logic push;
	logic full;

	assign req_stall = full;
	assign push = req_valid && !full;

	vsas_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	vsas_step #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.req(req),
		.cfg(cfg),
		.res(step_res)
	);

	vsas_oq u_oq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(step_res),
		.full(full),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);
endmodule
`default_nettype wire

// File: rtl/core/vsas_cfg.sv
// Configuration register bank with reset values.
`default_nettype none
module vsas_cfg
	import vsas_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t cfg
);
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flow_high_limit <= 16'd10000;
			cfg_q.flow_low_limit <= 16'd500;
			cfg_q.hr_high_limit <= 12'd1800;
			cfg_q.hr_low_limit <= 12'd400;
			cfg_q.hr_high_run <= 8'd3;
			cfg_q.flow_low_run <= 8'd3;
			cfg_q.hr_low_run <= 8'd3;
			cfg_q.alarm_ack_limit <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FLOW_HIGH_LIMIT: cfg_q.flow_high_limit <= cfg_data;
				CFG_FLOW_LOW_LIMIT: cfg_q.flow_low_limit <= cfg_data;
				CFG_HR_HIGH_LIMIT: cfg_q.hr_high_limit <= cfg_data[11:0];
				CFG_HR_LOW_LIMIT: cfg_q.hr_low_limit <= cfg_data[11:0];
				CFG_HR_HIGH_RUN: cfg_q.hr_high_run <= cfg_data[7:0];
				CFG_FLOW_LOW_RUN: cfg_q.flow_low_run <= cfg_data[7:0];
				CFG_HR_LOW_RUN: cfg_q.hr_low_run <= cfg_data[7:0];
				CFG_ALARM_ACK_LIMIT: cfg_q.alarm_ack_limit <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// File: rtl/core/vsas_step.sv
// Supervisor state machine: state registers and per-beat next-state logic.
`default_nettype none
module vsas_step
	import vsas_pkg::*;
#(
	parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input req_t req,
	input cfg_t cfg,
	output res_t res
);
	mode_t mode_q, mode_d;
	why_t why_q, why_d;
	logic [7:0] calib_q, calib_d;
	logic [7:0] high_q, high_d;
	logic [7:0] lflow_q, lflow_d;
	logic [7:0] lrate_q, lrate_d;
	logic [7:0] unack_q, unack_d;
	logic alarm;
	logic hr_high, fl_low, hr_low;
	logic [7:0] high_inc, lflow_inc, lrate_inc, unack_inc, calib_inc;

	localparam logic [7:0] CalibTarget = 8'(CALIB_SAMPLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ST_INIT;
			why_q <= WHY_NONE;
			calib_q <= '0;
			high_q <= '0;
			lflow_q <= '0;
			lrate_q <= '0;
			unack_q <= '0;
		end else if (push) begin
			mode_q <= mode_d;
			why_q <= why_d;
			calib_q <= calib_d;
			high_q <= high_d;
			lflow_q <= lflow_d;
			lrate_q <= lrate_d;
			unack_q <= unack_d;
		end
	end

	always_comb begin
		hr_high = req.heart_rate > cfg.hr_high_limit;
		fl_low = req.flow_rate < cfg.flow_low_limit;
		hr_low = req.heart_rate < cfg.hr_low_limit;
		high_inc = sat_inc(high_q);
		lflow_inc = sat_inc(lflow_q);
		lrate_inc = sat_inc(lrate_q);
		unack_inc = sat_inc(unack_q);
		calib_inc = sat_inc(calib_q);

		mode_d = mode_q;
		why_d = why_q;
		calib_d = calib_q;
		high_d = high_q;
		lflow_d = lflow_q;
		lrate_d = lrate_q;
		unack_d = unack_q;
		alarm = 1'b0;

		case (req_code_t'(req.req_type))
			REQ_SAMPLE: begin
				case (mode_q)
					ST_INIT: begin
						mode_d = ST_CALIB;
						calib_d = '0;
					end
					ST_CALIB: begin
						calib_d = calib_inc;
						if (calib_inc >= CalibTarget) mode_d = ST_MON;
					end
					ST_MON: begin
						if (req.flow_rate > cfg.flow_high_limit) begin
							why_d = WHY_OVERDOSE;
							mode_d = ST_HALT;
							alarm = 1'b1;
						end else if (hr_high && high_inc >= cfg.hr_high_run) begin
							high_d = high_inc;
							why_d = WHY_TACHY;
							mode_d = ST_HALT;
							alarm = 1'b1;
						end else begin
							high_d = hr_high ? high_inc : 8'd0;
							lflow_d = fl_low ? lflow_inc : 8'd0;
							lrate_d = hr_low ? lrate_inc : 8'd0;
							if ((fl_low && lflow_inc >= cfg.flow_low_run) ||
							    (hr_low && lrate_inc >= cfg.hr_low_run)) begin
								alarm = 1'b1;
								mode_d = ST_ALARM;
							end
						end
					end
					ST_ALARM: begin
						unack_d = unack_inc;
						if (unack_inc >= cfg.alarm_ack_limit) begin
							why_d = WHY_UNACKED;
							mode_d = ST_HALT;
							alarm = 1'b1;
						end
					end
					default: ;
				endcase
			end
			REQ_ACK: begin
				if (mode_q == ST_ALARM) begin
					unack_d = '0;
					lflow_d = '0;
					lrate_d = '0;
					mode_d = ST_MON;
				end
			end
			REQ_RESET: begin
				mode_d = ST_INIT;
				why_d = WHY_NONE;
				calib_d = '0;
				high_d = '0;
				lflow_d = '0;
				lrate_d = '0;
				unack_d = '0;
			end
			default: ;
		endcase

		res.fsm_state = mode_d;
		res.alarm_raised = alarm;
		res.halt_reason = why_d;
	end
endmodule
`default_nettype wire

// File: rtl/core/vsas_oq.sv
// Result register with a skid stage so the input stall is registered and never depends directly on the output stall.
`default_nettype none
module vsas_oq
	import vsas_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input res_t push_data,
	output logic full,
	output logic res_valid,
	input wire logic res_stall,
	output res_t res
);
	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;
	logic out_free;

	assign out_free = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full = skid_valid_q;
	assign res_valid = out_valid_q;
	assign res = out_q;
endmodule
`default_nettype wire

// File: tb/vsas_status_checker.sv
// Status checker for the vital sign supervisor: predicts every result beat and compares it.
module vsas_status_checker
	import vsas_pkg::*;
#(
	parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic res_valid,
	input logic res_stall,
	input res_t res,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output int fail_count,
	output int outstanding
);
	cfg_t lim;
	mode_t mode_q;
	why_t why_q;
	logic [7:0] calib_seen;
	logic [7:0] tachy_run;
	logic [7:0] dry_run;
	logic [7:0] brady_run;
	logic [7:0] unacked;
	res_t status_due[$];

	function automatic logic [7:0] inc_sat(input logic [7:0] v);
		return (v == 8'd255) ? v : v + 8'd1;
	endfunction

	function automatic void clear_status();
		mode_q = ST_INIT;
		why_q = WHY_NONE;
		calib_seen = '0;
		tachy_run = '0;
		dry_run = '0;
		brady_run = '0;
		unacked = '0;
	endfunction

	function automatic res_t apply_event(input req_t r);
		logic raised;
		logic halted;
		res_t o;
		raised = 1'b0;
		halted = 1'b0;
		case (r.req_type)
		REQ_SAMPLE: begin
			case (mode_q)
			ST_INIT: begin
				mode_q = ST_CALIB;
				calib_seen = '0;
			end
			ST_CALIB: begin
				calib_seen = inc_sat(calib_seen);
				if (calib_seen >= CALIB_SAMPLES)
					mode_q = ST_MON;
			end
			ST_MON: begin
				if (r.flow_rate > lim.flow_high_limit) begin
					why_q = WHY_OVERDOSE;
					mode_q = ST_HALT;
					raised = 1'b1;
					halted = 1'b1;
				end else if (r.heart_rate > lim.hr_high_limit) begin
					tachy_run = inc_sat(tachy_run);
					if (tachy_run >= lim.hr_high_run) begin
						why_q = WHY_TACHY;
						mode_q = ST_HALT;
						raised = 1'b1;
						halted = 1'b1;
					end
				end else begin
					tachy_run = '0;
				end
				if (!halted) begin
					if (r.flow_rate < lim.flow_low_limit) begin
						dry_run = inc_sat(dry_run);
						if (dry_run >= lim.flow_low_run)
							raised = 1'b1;
					end else begin
						dry_run = '0;
					end
					if (r.heart_rate < lim.hr_low_limit) begin
						brady_run = inc_sat(brady_run);
						if (brady_run >= lim.hr_low_run)
							raised = 1'b1;
					end else begin
						brady_run = '0;
					end
					if (raised)
						mode_q = ST_ALARM;
				end
			end
			ST_ALARM: begin
				unacked = inc_sat(unacked);
				if (unacked >= lim.alarm_ack_limit) begin
					why_q = WHY_UNACKED;
					mode_q = ST_HALT;
					raised = 1'b1;
				end
			end
			default: ;
			endcase
		end
		REQ_ACK: begin
			if (mode_q == ST_ALARM) begin
				unacked = '0;
				dry_run = '0;
				brady_run = '0;
				mode_q = ST_MON;
			end
		end
		REQ_RESET: clear_status();
		default: ;
		endcase
		o.fsm_state = mode_q;
		o.alarm_raised = raised;
		o.halt_reason = why_q;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			lim.flow_high_limit = 16'd10000;
			lim.flow_low_limit = 16'd500;
			lim.hr_high_limit = 12'd1800;
			lim.hr_low_limit = 12'd400;
			lim.hr_high_run = 8'd3;
			lim.flow_low_run = 8'd3;
			lim.hr_low_run = 8'd3;
			lim.alarm_ack_limit = 8'd10;
			clear_status();
			status_due.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (status_due.size() == 0) begin
					$display("%0t: status beat with none expected: state %0d alarm %0d reason %0d",
						$time, res.fsm_state, res.alarm_raised, res.halt_reason);
					fail_count++;
				end else begin
					want = status_due.pop_front();
					if (res.fsm_state !== want.fsm_state
							|| res.alarm_raised !== want.alarm_raised
							|| res.halt_reason !== want.halt_reason) begin
						$display("%0t: expected state %0d alarm %0d reason %0d, got %0d %0d %0d",
							$time, want.fsm_state, want.alarm_raised, want.halt_reason,
							res.fsm_state, res.alarm_raised, res.halt_reason);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				status_due.push_back(apply_event(req));
			if (cfg_we) begin
				case (cfg_index)
				CFG_FLOW_HIGH_LIMIT: lim.flow_high_limit = cfg_data;
				CFG_FLOW_LOW_LIMIT: lim.flow_low_limit = cfg_data;
				CFG_HR_HIGH_LIMIT: lim.hr_high_limit = cfg_data[11:0];
				CFG_HR_LOW_LIMIT: lim.hr_low_limit = cfg_data[11:0];
				CFG_HR_HIGH_RUN: lim.hr_high_run = cfg_data[7:0];
				CFG_FLOW_LOW_RUN: lim.flow_low_run = cfg_data[7:0];
				CFG_HR_LOW_RUN: lim.hr_low_run = cfg_data[7:0];
				default: lim.alarm_ack_limit = cfg_data[7:0];
				endcase
			end
			outstanding = status_due.size();
		end
	end
endmodule

// File: tb/vital_sign_alarm_supervisor_unit_test.sv
// Testbench top for the vital sign supervisor: clock, reset, stimulus, limits and verdict.
module vital_sign_alarm_supervisor_unit_test;
	import vsas_pkg::*;

	localparam logic [1:0] REQ_UNDEF = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int LVL_OK = 0;
	localparam int LVL_LOW = 1;
	localparam int LVL_HIGH = 2;
	localparam int LVL_EDGE = 3;
	localparam int LVL_ANY = 4;
	localparam int MOOD_CALM = 0;
	localparam int MOOD_DRY = 1;
	localparam int MOOD_BRADY = 2;
	localparam int MOOD_TACHY = 3;
	localparam int MOOD_MIXED = 4;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic res_valid;
	logic res_stall;
	res_t res;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count;
	int outstanding;
	int quiet = 0;
	int sent;
	bit tx_calm;
	cfg_t knobs;

	vital_sign_alarm_supervisor_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	vsas_status_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic req_t make_req(input logic [1:0] kind, input logic [15:0] flow,
			input logic [11:0] hr);
		req_t r;
		r.req_type = kind;
		r.flow_rate = flow;
		r.heart_rate = hr;
		return r;
	endfunction

	function automatic logic [15:0] pick_flow(input int lvl);
		logic [15:0] v;
		v = $urandom;
		case (lvl)
		LVL_OK: begin
			if (knobs.flow_low_limit <= knobs.flow_high_limit)
				v = $urandom_range(knobs.flow_high_limit, knobs.flow_low_limit);
		end
		LVL_LOW: begin
			if (knobs.flow_low_limit == 16'd0)
				v = 16'd0;
			else
				v = $urandom_range(knobs.flow_low_limit - 1, 0);
		end
		LVL_HIGH: begin
			if (knobs.flow_high_limit == 16'hFFFF)
				v = 16'hFFFF;
			else
				v = $urandom_range(16'hFFFF, knobs.flow_high_limit + 1);
		end
		LVL_EDGE: begin
			case ($urandom_range(3))
			0: v = knobs.flow_low_limit - 16'd1;
			1: v = knobs.flow_low_limit;
			2: v = knobs.flow_high_limit;
			default: v = knobs.flow_high_limit + 16'd1;
			endcase
		end
		default: ;
		endcase
		return v;
	endfunction

	function automatic logic [11:0] pick_hr(input int lvl);
		logic [11:0] v;
		v = $urandom;
		case (lvl)
		LVL_OK: begin
			if (knobs.hr_low_limit <= knobs.hr_high_limit)
				v = $urandom_range(knobs.hr_high_limit, knobs.hr_low_limit);
		end
		LVL_LOW: begin
			if (knobs.hr_low_limit == 12'd0)
				v = 12'd0;
			else
				v = $urandom_range(knobs.hr_low_limit - 1, 0);
		end
		LVL_HIGH: begin
			if (knobs.hr_high_limit == 12'hFFF)
				v = 12'hFFF;
			else
				v = $urandom_range(12'hFFF, knobs.hr_high_limit + 1);
		end
		LVL_EDGE: begin
			case ($urandom_range(3))
			0: v = knobs.hr_low_limit - 12'd1;
			1: v = knobs.hr_low_limit;
			2: v = knobs.hr_high_limit;
			default: v = knobs.hr_high_limit + 12'd1;
			endcase
		end
		default: ;
		endcase
		return v;
	endfunction

	function automatic cfg_t phase_limits(input int p);
		cfg_t k;
		k.flow_high_limit = $urandom_range(20000, 5000);
		k.flow_low_limit = $urandom_range(1500, 100);
		k.hr_high_limit = $urandom_range(2200, 1400);
		k.hr_low_limit = $urandom_range(600, 200);
		k.hr_high_run = $urandom_range(4, 1);
		k.flow_low_run = $urandom_range(4, 1);
		k.hr_low_run = $urandom_range(4, 1);
		k.alarm_ack_limit = $urandom_range(6, 1);
		case (p)
		0: begin
			k.flow_high_limit = 16'd10000;
			k.flow_low_limit = 16'd500;
			k.hr_high_limit = 12'd1800;
			k.hr_low_limit = 12'd400;
			k.hr_high_run = 8'd3;
			k.flow_low_run = 8'd3;
			k.hr_low_run = 8'd3;
			k.alarm_ack_limit = 8'd10;
		end
		2: begin
			k.flow_high_limit = 16'hFFFF;
			k.flow_low_limit = 16'hFFFF;
			k.hr_high_limit = 12'hFFF;
			k.hr_low_limit = 12'hFFF;
			k.hr_high_run = 8'd255;
			k.flow_low_run = 8'd255;
			k.hr_low_run = 8'd2;
			k.alarm_ack_limit = 8'd255;
		end
		3: begin
			k.flow_high_limit = 16'd0;
			k.flow_low_limit = 16'd0;
			k.hr_high_limit = 12'd0;
			k.hr_low_limit = 12'd0;
			k.hr_high_run = 8'd1;
			k.flow_low_run = 8'd1;
			k.hr_low_run = 8'd1;
			k.alarm_ack_limit = 8'd1;
		end
		// zero run limits trip on the first counted sample
		4: begin
			k.hr_high_run = 8'd0;
			k.flow_low_run = 8'd0;
			k.hr_low_run = 8'd0;
			k.alarm_ack_limit = 8'd0;
		end
		5: begin
			k.flow_high_limit = $urandom;
			k.flow_low_limit = $urandom;
			k.hr_high_limit = $urandom;
			k.hr_low_limit = $urandom;
		end
		default: ;
		endcase
		return k;
	endfunction

	// upper bits of narrow registers carry junk
	function automatic logic [CFG_DATA_W-1:0] limit_word(input cfg_t k, input cfg_idx_t idx);
		logic [CFG_DATA_W-1:0] w;
		w = $urandom;
		case (idx)
		CFG_FLOW_HIGH_LIMIT: w = k.flow_high_limit;
		CFG_FLOW_LOW_LIMIT: w = k.flow_low_limit;
		CFG_HR_HIGH_LIMIT: w[11:0] = k.hr_high_limit;
		CFG_HR_LOW_LIMIT: w[11:0] = k.hr_low_limit;
		CFG_HR_HIGH_RUN: w[7:0] = k.hr_high_run;
		CFG_FLOW_LOW_RUN: w[7:0] = k.flow_low_run;
		CFG_HR_LOW_RUN: w[7:0] = k.hr_low_run;
		default: w[7:0] = k.alarm_ack_limit;
		endcase
		return w;
	endfunction

	task automatic send_beat(input req_t r);
		int gap;
		if (sent % 32 == 0)
			tx_calm = ($urandom_range(3) == 0);
		gap = tx_calm ? 0 : $urandom_range(7);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic program_limits(input cfg_t k);
		for (int i = 0; i <= CFG_ALARM_ACK_LIMIT; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= limit_word(k, cfg_idx_t'(i));
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		knobs = k;
	endtask

	// soft reset, walk through calibration, then a biased burst in monitoring
	task automatic run_episode(input int len);
		int mood;
		int ack_pct;
		int lvl_f;
		int lvl_h;
		int roll;
		req_t r;
		mood = $urandom_range(MOOD_MIXED);
		ack_pct = $urandom_range(20);
		send_beat(make_req(REQ_RESET, $urandom, $urandom));
		for (int k = 0; k <= CALIB_SAMPLES_DEF; k++)
			send_beat(make_req(REQ_SAMPLE, $urandom, $urandom));
		for (int k = 0; k < len; k++) begin
			roll = $urandom_range(99);
			if (roll < 3) begin
				r = make_req(REQ_UNDEF, $urandom, $urandom);
			end else if (roll < 3 + ack_pct) begin
				r = make_req(REQ_ACK, $urandom, $urandom);
			end else if (roll < 5 + ack_pct) begin
				r = make_req(REQ_RESET, $urandom, $urandom);
			end else begin
				lvl_f = LVL_OK;
				lvl_h = LVL_OK;
				if ($urandom_range(3) == 0) begin
					lvl_f = $urandom_range(LVL_ANY);
					lvl_h = $urandom_range(LVL_ANY);
				end else begin
					case (mood)
					MOOD_DRY: lvl_f = LVL_LOW;
					MOOD_BRADY: lvl_h = LVL_LOW;
					MOOD_TACHY: lvl_h = LVL_HIGH;
					MOOD_MIXED: begin
						lvl_f = $urandom_range(LVL_HIGH);
						lvl_h = $urandom_range(LVL_HIGH);
					end
					default: ;
					endcase
				end
				r = make_req(REQ_SAMPLE, pick_flow(lvl_f), pick_hr(lvl_h));
			end
			send_beat(r);
		end
	endtask

	initial begin
		int gap;
		int taken;
		bit calm;
		res_stall = 1'b0;
		taken = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (taken % 40 == 0)
				calm = ($urandom_range(3) == 0);
			gap = calm ? 0 : $urandom_range(7);
			// long hold-off so the block backs up into the request side
			if (taken == 50 || taken == 300)
				gap = 150;
			if (gap != 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid)
				@(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_FLOW_HIGH_LIMIT;
		cfg_data = '0;
		sent = 0;
		tx_calm = 1'b0;
		knobs = phase_limits(0);
		wait (arst_n === 1'b1);
		@(negedge clk);

		send_beat(make_req(REQ_UNDEF, 16'hFFFF, 12'hFFF));
		send_beat(make_req(REQ_ACK, 16'h0000, 12'h000));
		send_beat(make_req(REQ_SAMPLE, 16'h0000, 12'h000));
		for (int k = 0; k < CALIB_SAMPLES_DEF; k++)
			send_beat(make_req(REQ_SAMPLE, k[0] ? 16'hFFFF : 16'h5A5A, k[0] ? 12'hFFF : 12'hA5A));
		send_beat(make_req(REQ_SAMPLE, 16'd10000, 12'd1800));
		send_beat(make_req(REQ_SAMPLE, 16'd500, 12'd400));
		send_beat(make_req(REQ_SAMPLE, 16'd10001, 12'd1801));
		send_beat(make_req(REQ_SAMPLE, 16'd0, 12'd0));
		send_beat(make_req(REQ_ACK, 16'hFFFF, 12'hFFF));
		send_beat(make_req(REQ_RESET, 16'hFFFF, 12'hFFF));

		for (int p = 1; p <= 5; p++) begin
			settle();
			program_limits(phase_limits(p));
			repeat (2) run_episode($urandom_range(30, 15));
		end

		settle();
		repeat (3) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
